@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL. Each takes a label, a clock,
// an active-low reset and the antecedent and consequent expressions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk_i, rst_ni, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!(rst_ni)) (ante) |-> (cons)) \
		else $error("Assertion failed: same-cycle implication does not hold");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk_i, rst_ni, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!(rst_ni)) (ante) |=> (cons)) \
		else $error("Assertion failed: next-cycle implication does not hold");

`endif

@@ hw/rtl/wspt_pkg.sv @@
// ----------------------------------------------------------------------------
// Weekly scheduled pulse timer package
// Types, status codes, register indexes and build constants shared by the
// timer's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wspt_pkg;

	// Build constants of the timer.
	localparam logic [31:0] CHECK_INTERVAL_MS = 32'd1000;
	localparam bit          HAS_OUTPUT        = 1'b1;
	localparam logic [31:0] MIN_PULSE_MS      = 32'd100;
	localparam logic [31:0] MAX_PULSE_MS      = 32'd600000;

	// Calendar constants.
	localparam int MIN_PER_HOUR  = 60;
	localparam int HOURS_PER_DAY = 24;
	localparam int MIN_PER_DAY   = HOURS_PER_DAY * MIN_PER_HOUR;
	localparam int MAX_HOUR      = HOURS_PER_DAY - 1;
	localparam int MAX_MINUTE    = MIN_PER_HOUR - 1;
	localparam int DAYS_PER_WEEK = 7;

	// Field widths.
	localparam int DAY_W      = 3;
	localparam int HOUR_W     = 5;
	localparam int MINUTE_W   = 6;
	localparam int DURATION_W = 20;
	localparam int MS_W       = 32;
	localparam int WEEK_MIN_W = 14;

	// A feed day of seven selects every day of the week.
	localparam logic [DAY_W-1:0] DAY_ANY = DAY_W'(DAYS_PER_WEEK);

	// Configuration port.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = DURATION_W;

	localparam logic [CFG_INDEX_W-1:0] REG_FEEDING_ENABLED  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FEED_DAY         = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FEED_HOUR        = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_FEED_MINUTE      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_FEED_DURATION_MS = 3'd4;

	// Register values after reset.
	localparam logic [DAY_W-1:0]      DAY_RESET      = 3'd7;
	localparam logic [HOUR_W-1:0]     HOUR_RESET     = 5'd8;
	localparam logic [MINUTE_W-1:0]   MINUTE_RESET   = 6'd0;
	localparam logic [DURATION_W-1:0] DURATION_RESET = 20'd3000;

	typedef enum logic [1:0] {
		ST_DISABLED = 2'd0,
		ST_IDLE     = 2'd1,
		ST_FEEDING  = 2'd2,
		ST_BLOCKED  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CAUSE_NONE      = 2'd0,
		CAUSE_NO_OUTPUT = 2'd1,
		CAUSE_NO_TIME   = 2'd2
	} cause_t;

	// Settings held by the configuration registers.
	typedef struct packed {
		logic                  feeding_enabled;
		logic [DAY_W-1:0]      feed_day;
		logic [HOUR_W-1:0]     feed_hour;
		logic [MINUTE_W-1:0]   feed_minute;
		logic [DURATION_W-1:0] feed_duration_ms;
	} cfg_t;

	// One input beat.
	typedef struct packed {
		logic                mode;
		logic [MS_W-1:0]     now_ms;
		logic                clock_valid;
		logic [DAY_W-1:0]    wall_weekday;
		logic [HOUR_W-1:0]   wall_hour;
		logic [MINUTE_W-1:0] wall_minute;
	} in_item_t;

	// One result beat.
	typedef struct packed {
		logic    drive_on;
		status_t feeder_status;
		cause_t  block_cause;
		logic    feed_started;
		logic    feed_completed;
		logic    request_refused;
		logic    check_skipped;
	} out_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/weekly_scheduled_pulse_timer.sv @@
// ----------------------------------------------------------------------------
// Weekly scheduled pulse timer
// Weekly alarm driving one pulse output, fed by periodic checks and manual
// feed requests. Each input beat yields exactly one result beat.
//
//   Channel  Signals                          Beat carries
//   in       in_valid, in_stall, in_data      check or manual request
//   out      out_valid, out_stall, out_data   output level and status flags
//   cfg      cfg_we, cfg_index, cfg_data      one register write
//
// One beat is accepted per cycle while in_stall is low. A beat is held in the
// input register and is evaluated against the timer state in a single pass;
// the result register then holds the answer.
// Reset clears the timer state and loads the register defaults at once.
// While a result waits under out_stall, a beat still in the input register
// holds and in_stall rises; the input register frees as soon as out drains.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module weekly_scheduled_pulse_timer import wspt_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire in_item_t               in_data,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output out_item_t                   out_data
);

	cfg_t cfg;

	wspt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register and result register.
	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_q;

	// Timer state.
	logic                  running_q;
	status_t               status_q;
	logic [MS_W-1:0]       pulse_start_q;
	logic [MS_W-1:0]       last_check_q;
	logic [WEEK_MIN_W-1:0] last_wm_q;
	logic                  fired_once_q;

	// Next state and result of the beat in the input register.
	logic                  nxt_running;
	status_t               nxt_status;
	logic [MS_W-1:0]       nxt_pulse_start;
	logic [MS_W-1:0]       nxt_last_check;
	logic [WEEK_MIN_W-1:0] nxt_last_wm;
	logic                  nxt_fired_once;
	out_item_t             result;

	logic                  out_free;
	logic                  fire;
	logic [MS_W-1:0]       since_check;
	logic [MS_W-1:0]       since_start;
	logic                  early;
	logic                  pulse_done;
	logic [WEEK_MIN_W-1:0] week_min;
	logic                  slot_match;

	// Handshake: the input register advances whenever the result register
	// is empty or being drained.
	assign out_free = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Elapsed times with wrapping subtraction, and the week-minute.
	always_comb begin
		since_check = item_s1.now_ms - last_check_q;
		since_start = item_s1.now_ms - pulse_start_q;
		early       = since_check < CHECK_INTERVAL_MS;
		pulse_done  = since_start >= {{(MS_W-DURATION_W){1'b0}}, cfg.feed_duration_ms};
		week_min    = WEEK_MIN_W'(item_s1.wall_weekday) * WEEK_MIN_W'(MIN_PER_DAY)
			+ WEEK_MIN_W'(item_s1.wall_hour) * WEEK_MIN_W'(MIN_PER_HOUR)
			+ WEEK_MIN_W'(item_s1.wall_minute);
		slot_match  = (item_s1.wall_hour == cfg.feed_hour)
			&& (item_s1.wall_minute == cfg.feed_minute)
			&& ((cfg.feed_day == DAY_ANY) || (item_s1.wall_weekday == cfg.feed_day));
	end

	// Single-pass evaluation of one beat against the timer state.
	always_comb begin
		nxt_running     = running_q;
		nxt_status      = status_q;
		nxt_pulse_start = pulse_start_q;
		nxt_last_check  = last_check_q;
		nxt_last_wm     = last_wm_q;
		nxt_fired_once  = fired_once_q;
		result          = '0;

		if (item_s1.mode) begin
			// Manual request: ignores interval, enable and wall clock.
			if (!HAS_OUTPUT) begin
				nxt_status             = ST_BLOCKED;
				result.request_refused = 1'b1;
			end else if (running_q) begin
				result.request_refused = 1'b1;
			end else begin
				nxt_running         = 1'b1;
				nxt_pulse_start     = item_s1.now_ms;
				nxt_status          = ST_FEEDING;
				result.feed_started = 1'b1;
			end
		end else if (early) begin
			result.check_skipped = 1'b1;
		end else begin
			nxt_last_check = item_s1.now_ms;
			if (running_q) begin
				// The pulse ends once its duration has elapsed.
				if (pulse_done) begin
					nxt_running           = 1'b0;
					nxt_status            = cfg.feeding_enabled ? ST_IDLE : ST_DISABLED;
					result.feed_completed = 1'b1;
				end
			end else if (!HAS_OUTPUT) begin
				nxt_status = ST_BLOCKED;
			end else if (!cfg.feeding_enabled) begin
				nxt_status = ST_DISABLED;
			end else if (!item_s1.clock_valid) begin
				nxt_status = ST_BLOCKED;
			end else if (slot_match && (!fired_once_q || (last_wm_q != week_min))) begin
				// Scheduled feed, once per distinct week-minute.
				nxt_last_wm         = week_min;
				nxt_fired_once      = 1'b1;
				nxt_running         = 1'b1;
				nxt_pulse_start     = item_s1.now_ms;
				nxt_status          = ST_FEEDING;
				result.feed_started = 1'b1;
			end else begin
				nxt_status = ST_IDLE;
			end
		end

		result.drive_on      = nxt_running;
		result.feeder_status = nxt_status;
		if (nxt_status == ST_BLOCKED) begin
			result.block_cause = HAS_OUTPUT ? CAUSE_NO_TIME : CAUSE_NO_OUTPUT;
		end else begin
			result.block_cause = CAUSE_NONE;
		end
	end

	// Timer state commits when the beat moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q     <= 1'b0;
			status_q      <= ST_DISABLED;
			pulse_start_q <= '0;
			last_check_q  <= '0;
			last_wm_q     <= '0;
			fired_once_q  <= 1'b0;
		end else if (fire) begin
			running_q     <= nxt_running;
			status_q      <= nxt_status;
			pulse_start_q <= nxt_pulse_start;
			last_check_q  <= nxt_last_check;
			last_wm_q     <= nxt_last_wm;
			fired_once_q  <= nxt_fired_once;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A running pulse always reports the feeding status.
	`ASSERT_IMPLIES(a_running_feeding, clk, arst_n, running_q, status_q == ST_FEEDING)

	// A shown result with the output on reports feeding.
	`ASSERT_IMPLIES(a_drive_status, clk, arst_n, out_valid && out_data.drive_on,
		out_data.feeder_status == ST_FEEDING)

	// A feed never starts and ends on the same beat.
	`ASSERT_IMPLIES(a_start_end, clk, arst_n, out_valid,
		!(out_data.feed_started && out_data.feed_completed))

	// The input side stalls only behind a held result.
	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)

	// A blocked status always carries a cause.
	`ASSERT_IMPLIES(a_block_cause, clk, arst_n,
		out_valid && (out_data.feeder_status == ST_BLOCKED),
		out_data.block_cause != CAUSE_NONE)

endmodule

`default_nettype wire

@@ hw/rtl/wspt_cfg.sv @@
// ----------------------------------------------------------------------------
// Timer configuration registers
// Holds the schedule and pulse length. Every write is saturated into the
// legal range of its register; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module wspt_cfg import wspt_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                        cfg
);

	cfg_t cfg_q;

	logic [HOUR_W-1:0]     hour_sat;
	logic [MINUTE_W-1:0]   minute_sat;
	logic [MS_W-1:0]       dur_wide;
	logic [DURATION_W-1:0] dur_sat;

	// Saturate the written value for each register.
	always_comb begin
		hour_sat   = cfg_data[HOUR_W-1:0];
		minute_sat = cfg_data[MINUTE_W-1:0];
		if (hour_sat > HOUR_W'(MAX_HOUR)) begin
			hour_sat = HOUR_W'(MAX_HOUR);
		end
		if (minute_sat > MINUTE_W'(MAX_MINUTE)) begin
			minute_sat = MINUTE_W'(MAX_MINUTE);
		end
		// The upper bound fits the register, so the clamped value does too.
		dur_wide = {{(MS_W-DURATION_W){1'b0}}, cfg_data[DURATION_W-1:0]};
		if (dur_wide < MIN_PULSE_MS) begin
			dur_wide = MIN_PULSE_MS;
		end
		if (dur_wide > MAX_PULSE_MS) begin
			dur_wide = MAX_PULSE_MS;
		end
		dur_sat = dur_wide[DURATION_W-1:0];
	end

	// Register file write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.feeding_enabled  <= 1'b0;
			cfg_q.feed_day         <= DAY_RESET;
			cfg_q.feed_hour        <= HOUR_RESET;
			cfg_q.feed_minute      <= MINUTE_RESET;
			cfg_q.feed_duration_ms <= DURATION_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FEEDING_ENABLED:  cfg_q.feeding_enabled  <= cfg_data[0];
				REG_FEED_DAY:         cfg_q.feed_day         <= cfg_data[DAY_W-1:0];
				REG_FEED_HOUR:        cfg_q.feed_hour        <= hour_sat;
				REG_FEED_MINUTE:      cfg_q.feed_minute      <= minute_sat;
				REG_FEED_DURATION_MS: cfg_q.feed_duration_ms <= dur_sat;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire
